/* sv/i2cbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; used by i2cbs_core and i2c_master_bit_sequencer_unit.
package i2cbs_pkg;

    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int TICKS_W = 8;

    localparam logic [TICKS_W-1:0] TICKS_PER_US_RESET = 8'd8;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] write_byte;
        logic              send_ack;
        logic              sda_in;
    } item_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_listening;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_received;
        logic              rejected;
    } result_t;

endpackage

/* sv/i2cbs_core.sv */
`timescale 1ns / 1ps
// Bus sequencing state and its one-step update per transaction.
// Depends on i2cbs_pkg.
module i2cbs_core
    import i2cbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  item_t              item,
    input  logic [TICKS_W-1:0] ticks_per_us,
    output result_t            result
);

    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_ST_A     = 5'd1;
    localparam logic [4:0] PH_ST_B     = 5'd2;
    localparam logic [4:0] PH_SP_A     = 5'd3;
    localparam logic [4:0] PH_SP_B     = 5'd4;
    localparam logic [4:0] PH_SP_C     = 5'd5;
    localparam logic [4:0] PH_WR_SETUP = 5'd6;
    localparam logic [4:0] PH_WR_HIGH  = 5'd7;
    localparam logic [4:0] PH_WR_LOW   = 5'd8;
    localparam logic [4:0] PH_WA_SETUP = 5'd9;
    localparam logic [4:0] PH_WA_HIGH  = 5'd10;
    localparam logic [4:0] PH_WA_TAIL  = 5'd11;
    localparam logic [4:0] PH_RD_PREP  = 5'd12;
    localparam logic [4:0] PH_RD_HIGH  = 5'd13;
    localparam logic [4:0] PH_RD_LOW   = 5'd14;
    localparam logic [4:0] PH_RK_SETUP = 5'd15;
    localparam logic [4:0] PH_RK_HIGH  = 5'd16;
    localparam logic [4:0] PH_RK_LOW   = 5'd17;

    logic [4:0]         phase_reg,     phase_next;
    logic [3:0]         bit_count_reg, bit_count_next;
    logic [2:0]         wait_us_reg,   wait_us_next;
    logic [TICKS_W-1:0] prescale_reg,  prescale_next;
    logic [BYTE_W-1:0]  shift_reg,     shift_next;
    logic [BYTE_W-1:0]  read_data_reg, read_data_next;
    logic               ack_to_send_reg, ack_to_send_next;
    logic               ack_seen_reg,    ack_seen_next;
    logic               scl_reg,         scl_next;
    logic               sda_reg,         sda_next;
    logic               sda_in_mode_reg, sda_in_mode_next;

    logic               done;
    logic               rej;
    logic [TICKS_W-1:0] limit;
    logic [TICKS_W-1:0] prescale_inc;
    logic [2:0]         wait_dec;
    logic [3:0]         bit_inc;

    assign limit        = (ticks_per_us == '0) ? TICKS_W'(1) : ticks_per_us;
    assign prescale_inc = prescale_reg + TICKS_W'(1);
    assign wait_dec     = (wait_us_reg != 3'd0) ? wait_us_reg - 3'd1 : 3'd0;
    assign bit_inc      = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        wait_us_next     = wait_us_reg;
        prescale_next    = prescale_reg;
        shift_next       = shift_reg;
        read_data_next   = read_data_reg;
        ack_to_send_next = ack_to_send_reg;
        ack_seen_next    = ack_seen_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_in_mode_next = sda_in_mode_reg;
        done             = 1'b0;
        rej              = 1'b0;

        if (item.operation == OP_START || item.operation == OP_STOP ||
            item.operation == OP_WRITE || item.operation == OP_READ)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                prescale_next = '0;
                case (item.operation)
                    OP_START:
                    begin
                        scl_next     = 1'b1;
                        sda_next     = 1'b1;
                        phase_next   = PH_ST_A;
                        wait_us_next = 3'd5;
                    end
                    OP_STOP:
                    begin
                        sda_next     = 1'b0;
                        phase_next   = PH_SP_A;
                        wait_us_next = 3'd5;
                    end
                    OP_WRITE:
                    begin
                        // first bit goes out immediately
                        sda_next       = item.write_byte[BYTE_W-1];
                        shift_next     = {item.write_byte[BYTE_W-2:0], 1'b0};
                        bit_count_next = '0;
                        phase_next     = PH_WR_SETUP;
                        wait_us_next   = 3'd1;
                    end
                    default:
                    begin
                        ack_to_send_next = item.send_ack;
                        shift_next       = '0;
                        bit_count_next   = '0;
                        sda_next         = 1'b1;
                        sda_in_mode_next = 1'b1;
                        phase_next       = PH_RD_PREP;
                        wait_us_next     = 3'd2;
                    end
                endcase
            end
        end
        else if (item.operation == OP_TICK && phase_reg != PH_IDLE)
        begin
            prescale_next = prescale_inc;
            if (prescale_inc >= limit)
            begin
                prescale_next = '0;
                wait_us_next  = wait_dec;
                if (wait_dec == 3'd0)
                begin
                    // end of wait: step the sequence; prescale is already cleared above
                    case (phase_reg)
                        PH_ST_A:
                        begin
                            sda_next = 1'b0; phase_next = PH_ST_B; wait_us_next = 3'd5;
                        end
                        PH_ST_B:
                        begin
                            scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                        end
                        PH_SP_A:
                        begin
                            scl_next = 1'b1; phase_next = PH_SP_B; wait_us_next = 3'd5;
                        end
                        PH_SP_B:
                        begin
                            sda_next = 1'b1; phase_next = PH_SP_C; wait_us_next = 3'd5;
                        end
                        PH_SP_C:
                        begin
                            phase_next = PH_IDLE; done = 1'b1;
                        end
                        PH_WR_SETUP:
                        begin
                            scl_next = 1'b1; phase_next = PH_WR_HIGH; wait_us_next = 3'd3;
                        end
                        PH_WR_HIGH:
                        begin
                            scl_next = 1'b0; phase_next = PH_WR_LOW; wait_us_next = 3'd2;
                        end
                        PH_WR_LOW:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc < 4'd8)
                            begin
                                sda_next     = shift_reg[BYTE_W-1];
                                shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
                                phase_next   = PH_WR_SETUP;
                                wait_us_next = 3'd1;
                            end
                            else
                            begin
                                sda_next         = 1'b1;
                                sda_in_mode_next = 1'b1;
                                phase_next       = PH_WA_SETUP;
                                wait_us_next     = 3'd1;
                            end
                        end
                        PH_WA_SETUP:
                        begin
                            scl_next = 1'b1; phase_next = PH_WA_HIGH; wait_us_next = 3'd2;
                        end
                        PH_WA_HIGH:
                        begin
                            ack_seen_next    = ~item.sda_in;
                            scl_next         = 1'b0;
                            sda_in_mode_next = 1'b0;
                            phase_next       = PH_WA_TAIL;
                            wait_us_next     = 3'd1;
                        end
                        PH_WA_TAIL:
                        begin
                            phase_next = PH_IDLE; done = 1'b1;
                        end
                        PH_RD_PREP:
                        begin
                            scl_next = 1'b1; phase_next = PH_RD_HIGH; wait_us_next = 3'd5;
                        end
                        PH_RD_HIGH:
                        begin
                            shift_next   = {shift_reg[BYTE_W-2:0], item.sda_in};
                            scl_next     = 1'b0;
                            phase_next   = PH_RD_LOW;
                            wait_us_next = 3'd5;
                        end
                        PH_RD_LOW:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc < 4'd8)
                            begin
                                scl_next     = 1'b1;
                                phase_next   = PH_RD_HIGH;
                                wait_us_next = 3'd5;
                            end
                            else
                            begin
                                sda_in_mode_next = 1'b0;
                                sda_next         = ~ack_to_send_reg;
                                phase_next       = PH_RK_SETUP;
                                wait_us_next     = 3'd2;
                            end
                        end
                        PH_RK_SETUP:
                        begin
                            scl_next = 1'b1; phase_next = PH_RK_HIGH; wait_us_next = 3'd5;
                        end
                        PH_RK_HIGH:
                        begin
                            scl_next = 1'b0; phase_next = PH_RK_LOW; wait_us_next = 3'd2;
                        end
                        PH_RK_LOW:
                        begin
                            sda_next       = 1'b1;
                            read_data_next = shift_reg;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            wait_us_reg     <= '0;
            prescale_reg    <= '0;
            shift_reg       <= '0;
            read_data_reg   <= '0;
            ack_to_send_reg <= 1'b0;
            ack_seen_reg    <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_in_mode_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            wait_us_reg     <= wait_us_next;
            prescale_reg    <= prescale_next;
            shift_reg       <= shift_next;
            read_data_reg   <= read_data_next;
            ack_to_send_reg <= ack_to_send_next;
            ack_seen_reg    <= ack_seen_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            sda_in_mode_reg <= sda_in_mode_next;
        end
    end

    // result reflects the state after this transaction
    always_comb
    begin
        result.scl_level     = scl_next;
        result.sda_level     = sda_next;
        result.sda_listening = sda_in_mode_next;
        result.busy_res      = (phase_next != PH_IDLE);
        result.done_res      = done;
        result.read_data     = read_data_next;
        result.ack_received  = ack_seen_next;
        result.rejected      = rej;
    end

endmodule

/* sv/i2c_master_bit_sequencer_unit.sv */
`timescale 1ns / 1ps
// Top level of the I2C master bit sequencer: input register, core, result register.
// Depends on i2cbs_pkg and i2cbs_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item: a tick
//   with the sampled SDA level, or a start, stop, write-byte or read-byte command.
//   Output channel (out_valid / out_stall) returns exactly one result per item:
//   SCL level, SDA level and direction, busy, done pulse, last read byte, last
//   ACK seen and a rejected flag for a command that arrived while busy.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes ticks_per_us; it is
//   always ready and should only be written while the sequencer is idle.
//   Timing: the item is registered on accept, and its result is registered when the
//   output advances, raising out_valid. Throughput is one item per cycle while
//   out_stall is low, with a single-step state update between the two registers.
//   Reset clears both stages, returns the bus to idle with SCL and SDA released
//   high, SDA in output mode, and ticks_per_us to 8.
//   When the receiver stalls, the result register holds, the input register holds
//   the next item, and in_stall rises once both are occupied.
module i2c_master_bit_sequencer_unit
    import i2cbs_pkg::*;
#(
    parameter logic [TICKS_W-1:0] TICKS_RESET = TICKS_PER_US_RESET
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [BYTE_W-1:0]  write_byte,
    input  logic               send_ack,
    input  logic               sda_in,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               scl_level,
    output logic               sda_level,
    output logic               sda_listening,
    output logic               busy_res,
    output logic               done_res,
    output logic [BYTE_W-1:0]  read_data,
    output logic               ack_received,
    output logic               rejected,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TICKS_W-1:0] cfg_data
);

    logic               in_vld_reg;
    item_t              item_reg;
    logic               out_vld_reg;
    result_t            result_reg;
    result_t            core_result;
    logic [TICKS_W-1:0] ticks_per_us_reg;
    logic               advance;
    logic               step_en;

    assign advance   = !out_vld_reg || !out_stall;
    assign step_en   = in_vld_reg && advance;
    assign in_stall  = in_vld_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg <= TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ticks_per_us_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.operation  <= operation;
            item_reg.write_byte <= write_byte;
            item_reg.send_ack   <= send_ack;
            item_reg.sda_in     <= sda_in;
        end
    end

    i2cbs_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .item         (item_reg),
        .ticks_per_us (ticks_per_us_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = out_vld_reg;
    assign scl_level     = result_reg.scl_level;
    assign sda_level     = result_reg.sda_level;
    assign sda_listening = result_reg.sda_listening;
    assign busy_res      = result_reg.busy_res;
    assign done_res      = result_reg.done_res;
    assign read_data     = result_reg.read_data;
    assign ack_received  = result_reg.ack_received;
    assign rejected      = result_reg.rejected;

endmodule

/* bench/i2c_master_bit_sequencer_unit_checker.sv */
`timescale 1ns / 1ps
// Checker for the I2C master bit sequencer: watches the item, result and config
// channels, predicts each result and compares it field by field. Depends on i2cbs_pkg.
module i2c_master_bit_sequencer_unit_checker
    import i2cbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [BYTE_W-1:0]  write_byte,
    input  logic               send_ack,
    input  logic               sda_in,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               scl_level,
    input  logic               sda_level,
    input  logic               sda_listening,
    input  logic               busy_res,
    input  logic               done_res,
    input  logic [BYTE_W-1:0]  read_data,
    input  logic               ack_received,
    input  logic               rejected,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [TICKS_W-1:0] cfg_data,

    output int                 errors,
    output int                 pending
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ST_A, S_ST_B,
        S_SP_A, S_SP_B, S_SP_C,
        S_WR_SETUP, S_WR_HIGH, S_WR_LOW,
        S_WA_SETUP, S_WA_HIGH, S_WA_TAIL,
        S_RD_PREP, S_RD_HIGH, S_RD_LOW,
        S_RK_SETUP, S_RK_HIGH, S_RK_LOW
    } bus_state_e;

    // predicted bus state
    bus_state_e         st;
    logic [3:0]         bits;
    logic [2:0]         us_left;
    logic [7:0]         prescale;
    logic [7:0]         shifter;
    logic               ack_tx;
    logic               ack_rx;
    logic               scl_q;
    logic               sda_q;
    logic               listen_q;
    logic [7:0]         rdata_q;
    logic [TICKS_W-1:0] tpu;

    result_t            bus_expected_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic void enter(input bus_state_e nxt, input logic [2:0] us);
        st       = nxt;
        us_left  = us;
        prescale = 8'd0;
    endfunction

    function automatic void shift_out_bit();
        sda_q   = shifter[7];
        shifter = shifter << 1;
        enter(S_WR_SETUP, 3'd1);
    endfunction

    // action at the end of a wait; returns 1 when the command sequence ends
    function automatic logic wait_over(input logic sda);
        logic fin;
        fin = 1'b0;
        case (st)
            S_ST_A:     begin sda_q = 1'b0; enter(S_ST_B, 3'd5); end
            S_ST_B:     begin scl_q = 1'b0; st = S_IDLE; fin = 1'b1; end
            S_SP_A:     begin scl_q = 1'b1; enter(S_SP_B, 3'd5); end
            S_SP_B:     begin sda_q = 1'b1; enter(S_SP_C, 3'd5); end
            S_SP_C:     begin st = S_IDLE; fin = 1'b1; end
            S_WR_SETUP: begin scl_q = 1'b1; enter(S_WR_HIGH, 3'd3); end
            S_WR_HIGH:  begin scl_q = 1'b0; enter(S_WR_LOW, 3'd2); end
            S_WR_LOW:
            begin
                bits = bits + 4'd1;
                if (bits < 4'd8)
                begin
                    shift_out_bit();
                end
                else
                begin
                    sda_q    = 1'b1;
                    listen_q = 1'b1;
                    enter(S_WA_SETUP, 3'd1);
                end
            end
            S_WA_SETUP: begin scl_q = 1'b1; enter(S_WA_HIGH, 3'd2); end
            S_WA_HIGH:
            begin
                ack_rx   = ~sda;
                scl_q    = 1'b0;
                listen_q = 1'b0;
                enter(S_WA_TAIL, 3'd1);
            end
            S_WA_TAIL:  begin st = S_IDLE; fin = 1'b1; end
            S_RD_PREP:  begin scl_q = 1'b1; enter(S_RD_HIGH, 3'd5); end
            S_RD_HIGH:
            begin
                shifter = {shifter[6:0], sda};
                scl_q   = 1'b0;
                enter(S_RD_LOW, 3'd5);
            end
            S_RD_LOW:
            begin
                bits = bits + 4'd1;
                if (bits < 4'd8)
                begin
                    scl_q = 1'b1;
                    enter(S_RD_HIGH, 3'd5);
                end
                else
                begin
                    listen_q = 1'b0;
                    sda_q    = ~ack_tx;
                    enter(S_RK_SETUP, 3'd2);
                end
            end
            S_RK_SETUP: begin scl_q = 1'b1; enter(S_RK_HIGH, 3'd5); end
            S_RK_HIGH:  begin scl_q = 1'b0; enter(S_RK_LOW, 3'd2); end
            S_RK_LOW:
            begin
                sda_q   = 1'b1;
                rdata_q = shifter;
                st      = S_IDLE;
                fin     = 1'b1;
            end
            default:    st = S_IDLE;
        endcase
        return fin;
    endfunction

    function automatic result_t bus_step(input item_t it);
        result_t            r;
        logic [TICKS_W-1:0] lim;
        logic               fin;
        logic               rej;
        fin = 1'b0;
        rej = 1'b0;
        case (it.operation)
            OP_START, OP_STOP, OP_WRITE, OP_READ:
            begin
                if (st != S_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    case (it.operation)
                        OP_START:
                        begin
                            scl_q = 1'b1;
                            sda_q = 1'b1;
                            enter(S_ST_A, 3'd5);
                        end
                        OP_STOP:
                        begin
                            sda_q = 1'b0;
                            enter(S_SP_A, 3'd5);
                        end
                        OP_WRITE:
                        begin
                            shifter = it.write_byte;
                            bits    = 4'd0;
                            shift_out_bit();
                        end
                        default:
                        begin
                            ack_tx   = it.send_ack;
                            shifter  = 8'd0;
                            bits     = 4'd0;
                            sda_q    = 1'b1;
                            listen_q = 1'b1;
                            enter(S_RD_PREP, 3'd2);
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (st != S_IDLE)
                begin
                    lim      = (tpu == '0) ? TICKS_W'(1) : tpu;
                    prescale = prescale + 8'd1;
                    // compared against the live setting, so a lowered value ends the us
                    if (prescale >= lim)
                    begin
                        prescale = 8'd0;
                        if (us_left != 3'd0)
                            us_left = us_left - 3'd1;
                        if (us_left == 3'd0)
                            fin = wait_over(it.sda_in);
                    end
                end
            end
            default: ;
        endcase
        r.scl_level     = scl_q;
        r.sda_level     = sda_q;
        r.sda_listening = listen_q;
        r.busy_res      = (st != S_IDLE);
        r.done_res      = fin;
        r.read_data     = rdata_q;
        r.ack_received  = ack_rx;
        r.rejected      = rej;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   it;
        result_t want;
        if (!rst_n)
        begin
            st       = S_IDLE;
            bits     = 4'd0;
            us_left  = 3'd0;
            prescale = 8'd0;
            shifter  = 8'd0;
            ack_tx   = 1'b0;
            ack_rx   = 1'b0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            listen_q = 1'b0;
            rdata_q  = 8'd0;
            tpu      = TICKS_PER_US_RESET;
            bus_expected_q.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tpu = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (bus_expected_q.size() == 0)
                begin
                    errors++;
                    $error("result transaction with no item outstanding");
                end
                else
                begin
                    want = bus_expected_q.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(sda_level));
                    check_field("sda_listening", 8'(want.sda_listening),
                                8'(sda_listening));
                    check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(done_res));
                    check_field("read_data", want.read_data, read_data);
                    check_field("ack_received", 8'(want.ack_received), 8'(ack_received));
                    check_field("rejected", 8'(want.rejected), 8'(rejected));
                end
            end
            if (in_valid && !in_stall)
            begin
                it.operation  = operation;
                it.write_byte = write_byte;
                it.send_ack   = send_ack;
                it.sda_in     = sda_in;
                bus_expected_q.push_back(bus_step(it));
            end
            pending = bus_expected_q.size();
        end
    end

endmodule

/* bench/i2c_master_bit_sequencer_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the I2C master bit sequencer: clock, reset, stimulus and verdict.
// Depends on i2cbs_pkg, i2c_master_bit_sequencer_unit and the checker module.
module i2c_master_bit_sequencer_unit_tb;

    import i2cbs_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int REGIME_ITEMS = 180;
    localparam int SDA_LOW      = 0;
    localparam int SDA_HIGH     = 1;
    localparam int SDA_RAND     = 2;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [OP_W-1:0]    operation     = OP_TICK;
    logic [BYTE_W-1:0]  write_byte    = '0;
    logic               send_ack      = 1'b0;
    logic               sda_in        = 1'b1;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic               scl_level;
    logic               sda_level;
    logic               sda_listening;
    logic               busy_res;
    logic               done_res;
    logic [BYTE_W-1:0]  read_data;
    logic               ack_received;
    logic               rejected;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [TICKS_W-1:0] cfg_data      = '0;

    int                 errors;
    int                 pending;
    int                 gap_pct       = 0;
    int                 stall_pct     = 0;
    int                 items_done    = 0;
    int                 quiet         = 0;
    logic [TICKS_W-1:0] cur_tpu       = TICKS_PER_US_RESET;

    int                 gap_plan[3]   = '{37, 65, 0};
    int                 stall_plan[3] = '{65, 37, 0};
    logic [TICKS_W-1:0] tpu_pick[7]   = '{8'd0, 8'd1, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4};
    logic [OP_W-1:0]    cmd_pick[4]   = '{OP_START, OP_STOP, OP_WRITE, OP_READ};

    always #5 clk = ~clk;

    i2c_master_bit_sequencer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .write_byte    (write_byte),
        .send_ack      (send_ack),
        .sda_in        (sda_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scl_level     (scl_level),
        .sda_level     (sda_level),
        .sda_listening (sda_listening),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .read_data     (read_data),
        .ack_received  (ack_received),
        .rejected      (rejected),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    i2c_master_bit_sequencer_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .write_byte    (write_byte),
        .send_ack      (send_ack),
        .sda_in        (sda_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scl_level     (scl_level),
        .sda_level     (sda_level),
        .sda_listening (sda_listening),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .read_data     (read_data),
        .ack_received  (ack_received),
        .rejected      (rejected),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("i2c_master_bit_sequencer_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic put_item(input logic [OP_W-1:0] op, input logic [7:0] wb,
                            input logic ack, input logic sda);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        write_byte <= wb;
        send_ack   <= ack;
        sda_in     <= sda;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic tick_burst(input int n, input int sda_mode, input int noise_pct);
        logic s;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                put_item(OP_W'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                         1'($urandom));
            s = (sda_mode == SDA_RAND) ? 1'($urandom) : sda_mode[0];
            put_item(OP_TICK, 8'($urandom), 1'($urandom), s);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_ticks(input logic [TICKS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_tpu = v;
    endtask

    function automatic int bus_us(input logic [OP_W-1:0] op);
        case (op)
            OP_START: return 10;
            OP_STOP:  return 15;
            OP_WRITE: return 52;
            OP_READ:  return 91;
            default:  return 0;
        endcase
    endfunction

    // one command and the ticks it needs; sometimes cut short or padded with idle ticks
    task automatic bus_command(input logic [OP_W-1:0] op);
        int need;
        int n;
        need = bus_us(op) * ((cur_tpu == '0) ? 1 : int'(cur_tpu));
        n = need;
        case ($urandom_range(0, 9))
            0:       n = need - int'($urandom_range(1, 3));
            1, 2:    n = need + int'($urandom_range(1, 4));
            default: ;
        endcase
        put_item(op, 8'($urandom), 1'($urandom), 1'($urandom));
        tick_burst((n < need) ? n : need, SDA_RAND, 3);
        if (n > need)
            tick_burst(n - need, SDA_RAND, 0);
        items_done += 1 + need;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct   = gap_plan[0];
        stall_pct = stall_plan[0];

        // idle ticks and unused opcodes do nothing
        put_item(OP_TICK, 8'h00, 1'b0, 1'b0);
        put_item(OP_TICK, 8'hFF, 1'b1, 1'b1);
        for (int op = OP_READ + 1; op < 8; op++)
            put_item(op[OP_W-1:0], 8'($urandom), 1'($urandom), 1'($urandom));

        // start at the reset rate, then a zero rate that acts as one
        put_item(OP_START, 8'h5A, 1'b0, 1'b1);
        tick_burst(80, SDA_RAND, 0);
        drain();
        write_ticks(8'd0);

        // commands while busy are rejected
        put_item(OP_START, 8'h00, 1'b0, 1'b0);
        tick_burst(3, SDA_RAND, 0);
        put_item(OP_STOP, 8'h00, 1'b0, 1'b0);
        put_item(OP_READ, 8'h00, 1'b1, 1'b1);
        tick_burst(8, SDA_RAND, 0);

        put_item(OP_WRITE, 8'hFF, 1'b0, 1'b0);
        tick_burst(52, SDA_LOW, 0);
        put_item(OP_WRITE, 8'h00, 1'b1, 1'b1);
        tick_burst(52, SDA_HIGH, 0);
        put_item(OP_READ, 8'h00, 1'b1, 1'b0);
        tick_burst(91, SDA_HIGH, 0);
        put_item(OP_READ, 8'hFF, 1'b0, 1'b1);
        tick_burst(91, SDA_LOW, 0);
        put_item(OP_STOP, 8'h00, 1'b0, 1'b0);
        tick_burst(16, SDA_RAND, 0);

        // slowest rate, lowered mid-wait while the prescaler is past the new value
        drain();
        write_ticks(8'd255);
        put_item(OP_START, 8'h00, 1'b0, 1'b0);
        tick_burst(260, SDA_RAND, 0);
        drain();
        write_ticks(8'd1);
        tick_burst(12, SDA_RAND, 0);

        for (int k = 0; k < 3; k++)
        begin
            gap_pct    = gap_plan[k];
            stall_pct  = stall_plan[k];
            items_done = 0;
            while (items_done < REGIME_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    drain();
                    write_ticks(tpu_pick[$urandom_range(0, 6)]);
                end
                if ($urandom_range(0, 99) < 5)
                    drain();
                if ($urandom_range(0, 99) < 70)
                begin
                    // framed transfer: start, address, a few data bytes, stop
                    bus_command(OP_START);
                    bus_command(OP_WRITE);
                    repeat ($urandom_range(1, 3))
                        bus_command($urandom_range(0, 1) ? OP_READ : OP_WRITE);
                    bus_command(OP_STOP);
                end
                else
                begin
                    bus_command(cmd_pick[$urandom_range(0, 3)]);
                end
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("i2c_master_bit_sequencer_unit_tb OK");
        else
            $display("i2c_master_bit_sequencer_unit_tb NOT OK");
        $finish;
    end

endmodule
